// ===== hw/rtl/hgdp_pkg.sv =====
// Shared types and constants for the gamepad report-descriptor parser.
`default_nettype none
package hgdp_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELEM,
        ST_SUM
    } t_state;

    // Usage context
    typedef enum logic [2:0] {
        CTX_NONE,
        CTX_PAD,
        CTX_BUTTON,
        CTX_AXIS,
        CTX_HAT
    } t_ctx;

    // Record kinds on the output channel
    localparam logic [1:0] KIND_AXIS    = 2'd0;
    localparam logic [1:0] KIND_HAT     = 2'd1;
    localparam logic [1:0] KIND_BUTTON  = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // Short item prefix decoding
    localparam logic [7:0] TAG_MASK        = 8'hFC;
    localparam logic [1:0] SIZE_CODE_FOUR  = 2'd3;
    localparam logic [1:0] SIZE_CODE_ONE   = 2'd1;
    localparam logic [1:0] SIZE_CODE_TWO   = 2'd2;
    localparam logic [7:0] ITEM_USAGE_PAGE = 8'h04;
    localparam logic [7:0] ITEM_USAGE      = 8'h08;
    localparam logic [7:0] ITEM_LOG_MIN    = 8'h14;
    localparam logic [7:0] ITEM_LOG_MAX    = 8'h24;
    localparam logic [7:0] ITEM_PHY_MIN    = 8'h34;
    localparam logic [7:0] ITEM_PHY_MAX    = 8'h44;
    localparam logic [7:0] ITEM_REP_SIZE   = 8'h74;
    localparam logic [7:0] ITEM_INPUT      = 8'h80;
    localparam logic [7:0] ITEM_REPORT_ID  = 8'h84;
    localparam logic [7:0] ITEM_REP_COUNT  = 8'h94;

    // Usage values
    localparam logic [31:0] PAGE_BUTTON    = 32'h09;
    localparam logic [31:0] USAGE_JOYSTICK = 32'h04;
    localparam logic [31:0] USAGE_GAMEPAD  = 32'h05;
    localparam logic [31:0] USAGE_AXIS_LO  = 32'h30;
    localparam logic [31:0] USAGE_AXIS_HI  = 32'h36;
    localparam logic [31:0] USAGE_HAT      = 32'h39;

    // Input item flags: Data, Variable
    localparam logic [1:0] INPUT_DATA_VAR = 2'b10;

    // Offset after a report ID byte
    localparam logic [15:0] REPORT_ID_BITS = 16'd8;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_elem;
        logic emit_sum;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic start_emit;
        logic elem_final;
        logic last_pending;
        logic in_last;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/hgdp_ctrl.sv =====
// Controller state machine of the gamepad report-descriptor parser.
`default_nettype none
module hgdp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire hgdp_pkg::t_status i_status,
    output hgdp_pkg::t_cmd        o_cmd
);

    hgdp_pkg::t_state r_state;
    hgdp_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hgdp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.emit_elem = 1'b0;
        o_cmd.emit_sum  = 1'b0;
        case (r_state)
            hgdp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.start_emit) begin
                        n_state = hgdp_pkg::ST_ELEM;
                    end else if (i_status.in_last) begin
                        n_state = hgdp_pkg::ST_SUM;
                    end
                end
            end
            hgdp_pkg::ST_ELEM: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_elem = 1'b1;
                    if (i_status.elem_final) begin
                        n_state = i_status.last_pending ? hgdp_pkg::ST_SUM
                                                        : hgdp_pkg::ST_IDLE;
                    end
                end
            end
            hgdp_pkg::ST_SUM: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state        = hgdp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hgdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hgdp_datapath.sv =====
// Datapath: item assembly, parse state, element counters and output register.
`default_nettype none
module hgdp_datapath #(
    parameter int MAX_AXES       = 8,
    parameter int MAX_HAT_FIELDS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_desc_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_out_ready,
    input  wire hgdp_pkg::t_cmd    i_cmd,
    output hgdp_pkg::t_status      o_status,
    output logic                   o_out_valid,
    output logic [1:0]             o_record_kind,
    output logic [15:0]            o_bit_offset,
    output logic [7:0]             o_field_size,
    output logic [7:0]             o_field_count,
    output logic signed [31:0]     o_minimum,
    output logic signed [31:0]     o_maximum,
    output logic                   o_min_known,
    output logic                   o_max_known,
    output logic [13:0]            o_report_bytes,
    output logic [$clog2(MAX_AXES+1)-1:0]       o_axis_count,
    output logic [$clog2(MAX_HAT_FIELDS+1)-1:0] o_hat_count,
    output logic                   o_last_result
);

    localparam int AXW = $clog2(MAX_AXES + 1);
    localparam int HTW = $clog2(MAX_HAT_FIELDS + 1);

    // Parse state
    logic [7:0]       r_item_tag,   n_item_tag;
    logic [2:0]       r_args_left,  n_args_left;
    logic [31:0]      r_arg_accum,  n_arg_accum;
    hgdp_pkg::t_ctx   r_ctx,        n_ctx;
    logic             r_lmin_def,   n_lmin_def;
    logic             r_lmax_def,   n_lmax_def;
    logic             r_pmin_def,   n_pmin_def;
    logic             r_pmax_def,   n_pmax_def;
    logic [31:0]      r_lmin,       n_lmin;
    logic [31:0]      r_lmax,       n_lmax;
    logic [31:0]      r_pmin,       n_pmin;
    logic [31:0]      r_pmax,       n_pmax;
    logic [7:0]       r_elem_size,  n_elem_size;
    logic [7:0]       r_elem_count, n_elem_count;
    logic [15:0]      r_offset,     n_offset;
    logic             r_id_seen,    n_id_seen;
    logic             r_stopped,    n_stopped;
    logic [AXW-1:0]   r_axes,       n_axes;
    logic [HTW-1:0]   r_hats,       n_hats;

    // Element emission
    logic [1:0]       r_emit_kind,  n_emit_kind;
    logic [15:0]      r_emit_off,   n_emit_off;
    logic [7:0]       r_emit_left,  n_emit_left;
    logic             r_last_pend,  n_last_pend;

    // Output register
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [15:0]      r_bit_off;
    logic [7:0]       r_fsize;
    logic [7:0]       r_fcount;
    logic [31:0]      r_min;
    logic [31:0]      r_max;
    logic             r_min_known;
    logic             r_max_known;
    logic [13:0]      r_rep_bytes;
    logic [AXW-1:0]   r_axis_cnt;
    logic [HTW-1:0]   r_hat_cnt;
    logic             r_last_res;

    // Decode of the accepted byte
    logic [2:0]       w_len_new;
    logic [2:0]       w_tag_len;
    logic [2:0]       w_idx_full;
    logic [31:0]      w_accum;
    logic             w_item_go;
    logic [7:0]       w_item_tag;
    logic [31:0]      w_item_arg;
    logic [7:0]       w_item_kind;
    logic             w_input_var;
    logic             w_emit_any;
    logic [15:0]      w_prod;
    logic [16:0]      w_off_sum;
    logic [16:0]      w_emit_sum;
    logic [16:0]      w_rep_sum;
    logic             w_elem_final;
    logic             w_load;

    // Argument length from the size code of a prefix
    assign w_len_new  = (i_desc_byte[1:0] == hgdp_pkg::SIZE_CODE_FOUR) ? 3'd4
                                                                        : {1'b0, i_desc_byte[1:0]};
    assign w_tag_len  = (r_item_tag[1:0] == hgdp_pkg::SIZE_CODE_FOUR) ? 3'd4
                                                                       : {1'b0, r_item_tag[1:0]};
    assign w_idx_full = w_tag_len - r_args_left;
    assign w_accum    = r_arg_accum | ({24'd0, i_desc_byte} << {w_idx_full[1:0], 3'b000});

    // Item completion and argument sign extension
    always_comb begin
        w_item_go  = 1'b0;
        w_item_tag = i_desc_byte;
        w_item_arg = '0;
        if (!r_stopped) begin
            if (r_args_left == 3'd0) begin
                w_item_go = (w_len_new == 3'd0);
            end else if (r_args_left == 3'd1) begin
                w_item_go  = 1'b1;
                w_item_tag = r_item_tag;
                case (r_item_tag[1:0])
                    hgdp_pkg::SIZE_CODE_ONE: w_item_arg = {{24{w_accum[7]}}, w_accum[7:0]};
                    hgdp_pkg::SIZE_CODE_TWO: w_item_arg = {{16{w_accum[15]}}, w_accum[15:0]};
                    default:                 w_item_arg = w_accum;
                endcase
            end
        end
    end

    assign w_item_kind = w_item_tag & hgdp_pkg::TAG_MASK;
    assign w_input_var = w_item_go && (w_item_kind == hgdp_pkg::ITEM_INPUT)
                         && (w_item_arg[1:0] == hgdp_pkg::INPUT_DATA_VAR);

    // Does an Input item in the current context give at least one record
    always_comb begin
        case (r_ctx)
            hgdp_pkg::CTX_BUTTON: w_emit_any = 1'b1;
            hgdp_pkg::CTX_AXIS:   w_emit_any = (r_elem_count != 8'd0)
                                               && (r_axes < AXW'(MAX_AXES));
            hgdp_pkg::CTX_HAT:    w_emit_any = (r_elem_count != 8'd0)
                                               && (r_hats < HTW'(MAX_HAT_FIELDS));
            default:              w_emit_any = 1'b0;
        endcase
    end

    // Offset arithmetic
    assign w_prod     = {8'd0, r_elem_count} * {8'd0, r_elem_size};
    assign w_off_sum  = {1'b0, r_offset} + {1'b0, w_prod};
    assign w_emit_sum = {1'b0, r_emit_off} + {9'd0, r_elem_size};
    assign w_rep_sum  = {1'b0, r_offset} + 17'd7;

    // Current element is the last one of this Input item
    always_comb begin
        case (r_emit_kind)
            hgdp_pkg::KIND_AXIS: w_elem_final = (r_emit_left == 8'd1)
                                                || (r_axes == AXW'(MAX_AXES - 1));
            hgdp_pkg::KIND_HAT:  w_elem_final = (r_emit_left == 8'd1)
                                                || (r_hats == HTW'(MAX_HAT_FIELDS - 1));
            default:             w_elem_final = 1'b1;
        endcase
    end

    assign o_status.slot_free    = !r_out_valid || i_out_ready;
    assign o_status.start_emit   = w_input_var && w_emit_any;
    assign o_status.elem_final   = w_elem_final;
    assign o_status.last_pending = r_last_pend;
    assign o_status.in_last      = i_last_byte;

    // Next parse state
    always_comb begin
        n_item_tag   = r_item_tag;
        n_args_left  = r_args_left;
        n_arg_accum  = r_arg_accum;
        n_ctx        = r_ctx;
        n_lmin_def   = r_lmin_def;
        n_lmax_def   = r_lmax_def;
        n_pmin_def   = r_pmin_def;
        n_pmax_def   = r_pmax_def;
        n_lmin       = r_lmin;
        n_lmax       = r_lmax;
        n_pmin       = r_pmin;
        n_pmax       = r_pmax;
        n_elem_size  = r_elem_size;
        n_elem_count = r_elem_count;
        n_offset     = r_offset;
        n_id_seen    = r_id_seen;
        n_stopped    = r_stopped;
        n_axes       = r_axes;
        n_hats       = r_hats;
        n_emit_kind  = r_emit_kind;
        n_emit_off   = r_emit_off;
        n_emit_left  = r_emit_left;
        n_last_pend  = r_last_pend;

        if (i_cmd.accept) begin
            n_last_pend = i_last_byte;
            // item assembly
            if (!r_stopped) begin
                if (r_args_left == 3'd0) begin
                    if (w_len_new != 3'd0) begin
                        n_item_tag  = i_desc_byte;
                        n_args_left = w_len_new;
                        n_arg_accum = '0;
                    end
                end else begin
                    n_arg_accum = w_accum;
                    n_args_left = r_args_left - 3'd1;
                end
            end
            // complete item
            if (w_item_go) begin
                case (w_item_kind)
                    hgdp_pkg::ITEM_REPORT_ID: begin
                        if (r_id_seen) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_id_seen = (w_item_arg != 32'd0);
                            n_offset  = hgdp_pkg::REPORT_ID_BITS;
                        end
                    end
                    hgdp_pkg::ITEM_USAGE_PAGE: begin
                        if (w_item_arg == hgdp_pkg::PAGE_BUTTON && r_ctx == hgdp_pkg::CTX_PAD) begin
                            n_ctx = hgdp_pkg::CTX_BUTTON;
                        end
                    end
                    hgdp_pkg::ITEM_USAGE: begin
                        if (w_item_arg == hgdp_pkg::USAGE_JOYSTICK
                            || w_item_arg == hgdp_pkg::USAGE_GAMEPAD) begin
                            n_ctx = hgdp_pkg::CTX_PAD;
                        end else if (w_item_arg >= hgdp_pkg::USAGE_AXIS_LO
                                     && w_item_arg <= hgdp_pkg::USAGE_AXIS_HI) begin
                            if (r_ctx == hgdp_pkg::CTX_PAD) n_ctx = hgdp_pkg::CTX_AXIS;
                        end else if (w_item_arg == hgdp_pkg::USAGE_HAT) begin
                            if (r_ctx == hgdp_pkg::CTX_PAD) n_ctx = hgdp_pkg::CTX_HAT;
                        end
                    end
                    hgdp_pkg::ITEM_LOG_MIN: begin
                        n_lmin     = w_item_arg;
                        n_lmin_def = 1'b1;
                    end
                    hgdp_pkg::ITEM_LOG_MAX: begin
                        n_lmax     = w_item_arg;
                        n_lmax_def = 1'b1;
                    end
                    hgdp_pkg::ITEM_PHY_MIN: begin
                        n_pmin     = w_item_arg;
                        n_pmin_def = 1'b1;
                    end
                    hgdp_pkg::ITEM_PHY_MAX: begin
                        n_pmax     = w_item_arg;
                        n_pmax_def = 1'b1;
                    end
                    hgdp_pkg::ITEM_REP_SIZE: begin
                        n_elem_size = (|w_item_arg[31:8]) ? 8'hFF : w_item_arg[7:0];
                    end
                    hgdp_pkg::ITEM_REP_COUNT: begin
                        n_elem_count = (|w_item_arg[31:8]) ? 8'hFF : w_item_arg[7:0];
                    end
                    hgdp_pkg::ITEM_INPUT: begin
                        if (w_input_var && (r_ctx inside {hgdp_pkg::CTX_AXIS,
                                                          hgdp_pkg::CTX_HAT,
                                                          hgdp_pkg::CTX_BUTTON})) begin
                            n_ctx       = hgdp_pkg::CTX_PAD;
                            n_emit_off  = r_offset;
                            n_emit_left = (r_ctx == hgdp_pkg::CTX_BUTTON) ? 8'd1 : r_elem_count;
                            case (r_ctx)
                                hgdp_pkg::CTX_AXIS: n_emit_kind = hgdp_pkg::KIND_AXIS;
                                hgdp_pkg::CTX_HAT:  n_emit_kind = hgdp_pkg::KIND_HAT;
                                default:            n_emit_kind = hgdp_pkg::KIND_BUTTON;
                            endcase
                        end
                        n_offset = w_off_sum[16] ? 16'hFFFF : w_off_sum[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end

        // one element record per command
        if (i_cmd.emit_elem) begin
            n_emit_off  = w_emit_sum[16] ? 16'hFFFF : w_emit_sum[15:0];
            n_emit_left = r_emit_left - 8'd1;
            if (r_emit_kind == hgdp_pkg::KIND_AXIS) n_axes = r_axes + AXW'(1);
            if (r_emit_kind == hgdp_pkg::KIND_HAT)  n_hats = r_hats + HTW'(1);
        end
    end

    // Parse state registers; the summary returns them to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_sum) begin
            r_item_tag   <= '0;
            r_args_left  <= '0;
            r_arg_accum  <= '0;
            r_ctx        <= hgdp_pkg::CTX_NONE;
            r_lmin_def   <= 1'b0;
            r_lmax_def   <= 1'b0;
            r_pmin_def   <= 1'b0;
            r_pmax_def   <= 1'b0;
            r_elem_size  <= '0;
            r_elem_count <= '0;
            r_offset     <= '0;
            r_id_seen    <= 1'b0;
            r_stopped    <= 1'b0;
            r_axes       <= '0;
            r_hats       <= '0;
            r_emit_left  <= '0;
            r_last_pend  <= 1'b0;
        end else begin
            r_item_tag   <= n_item_tag;
            r_args_left  <= n_args_left;
            r_arg_accum  <= n_arg_accum;
            r_ctx        <= n_ctx;
            r_lmin_def   <= n_lmin_def;
            r_lmax_def   <= n_lmax_def;
            r_pmin_def   <= n_pmin_def;
            r_pmax_def   <= n_pmax_def;
            r_elem_size  <= n_elem_size;
            r_elem_count <= n_elem_count;
            r_offset     <= n_offset;
            r_id_seen    <= n_id_seen;
            r_stopped    <= n_stopped;
            r_axes       <= n_axes;
            r_hats       <= n_hats;
            r_emit_left  <= n_emit_left;
            r_last_pend  <= n_last_pend;
        end
    end

    // Bound values and emission scratch, only read behind their flags
    always_ff @(posedge i_clk) begin
        r_lmin      <= n_lmin;
        r_lmax      <= n_lmax;
        r_pmin      <= n_pmin;
        r_pmax      <= n_pmax;
        r_emit_kind <= n_emit_kind;
        r_emit_off  <= n_emit_off;
    end

    // Output valid
    assign w_load = i_cmd.emit_elem || i_cmd.emit_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sum) begin
            r_kind      <= hgdp_pkg::KIND_SUMMARY;
            r_bit_off   <= r_offset;
            r_fsize     <= '0;
            r_fcount    <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_min_known <= 1'b0;
            r_max_known <= 1'b0;
            r_rep_bytes <= w_rep_sum[16:3];
            r_axis_cnt  <= r_axes;
            r_hat_cnt   <= r_hats;
            r_last_res  <= 1'b1;
        end else if (i_cmd.emit_elem) begin
            r_kind      <= r_emit_kind;
            r_bit_off   <= r_emit_off;
            r_fsize     <= r_elem_size;
            r_fcount    <= (r_emit_kind == hgdp_pkg::KIND_BUTTON) ? r_elem_count : 8'd1;
            r_min       <= r_lmin_def ? r_lmin : (r_pmin_def ? r_pmin : 32'd0);
            r_max       <= r_lmax_def ? r_lmax : (r_pmax_def ? r_pmax : 32'd0);
            r_min_known <= r_lmin_def || r_pmin_def;
            r_max_known <= r_lmax_def || r_pmax_def;
            r_rep_bytes <= '0;
            r_axis_cnt  <= '0;
            r_hat_cnt   <= '0;
            r_last_res  <= w_elem_final && !r_last_pend;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_record_kind  = r_kind;
    assign o_bit_offset   = r_bit_off;
    assign o_field_size   = r_fsize;
    assign o_field_count  = r_fcount;
    assign o_minimum      = r_min;
    assign o_maximum      = r_max;
    assign o_min_known    = r_min_known;
    assign o_max_known    = r_max_known;
    assign o_report_bytes = r_rep_bytes;
    assign o_axis_count   = r_axis_cnt;
    assign o_hat_count    = r_hat_cnt;
    assign o_last_result  = r_last_res;

`ifndef ASSERT_OFF
    // A record is only loaded into a free output slot
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || i_out_ready))
        else $error("record loaded over a pending record");

    // Element counts never pass their limits
    a_count_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_axes <= AXW'(MAX_AXES)) && (r_hats <= HTW'(MAX_HAT_FIELDS)))
        else $error("element count beyond limit");

    // The summary clears the parse state
    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sum |=> (r_offset == 16'd0 && r_axes == '0 && r_hats == '0
                            && !r_stopped && r_args_left == 3'd0))
        else $error("parse state not cleared after summary");

    // A summary record always closes its byte
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == hgdp_pkg::KIND_SUMMARY) |-> r_last_res)
        else $error("summary record without last flag");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/hid_gamepad_descriptor_parser_top.sv =====
// Top level of the gamepad report-descriptor parser.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    i_desc_byte, i_last_byte
//   out      source     o_out_valid / i_out_ready  o_record_kind .. o_last_result
//
// A byte that gives no record is taken at once; the next can follow at once.
// An Input item that gives N element records holds the input until they are sent,
// one record per cycle through the single output register while the output takes
// them; a final byte adds the summary record. Stalls on the output hold it longer.
// Reset is synchronous and active low.
`default_nettype none
module hid_gamepad_descriptor_parser_top #(
    parameter int MAX_AXES       = 8,
    parameter int MAX_HAT_FIELDS = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_desc_byte,
    input  wire logic          i_last_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_record_kind,
    output logic [15:0]        o_bit_offset,
    output logic [7:0]         o_field_size,
    output logic [7:0]         o_field_count,
    output logic signed [31:0] o_minimum,
    output logic signed [31:0] o_maximum,
    output logic               o_min_known,
    output logic               o_max_known,
    output logic [13:0]        o_report_bytes,
    output logic [$clog2(MAX_AXES+1)-1:0]       o_axis_count,
    output logic [$clog2(MAX_HAT_FIELDS+1)-1:0] o_hat_count,
    output logic               o_last_result
);

    hgdp_pkg::t_cmd    w_cmd;
    hgdp_pkg::t_status w_status;

    // Sequencer
    hgdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Parse state and record output
    hgdp_datapath #(
        .MAX_AXES       (MAX_AXES),
        .MAX_HAT_FIELDS (MAX_HAT_FIELDS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc_byte    (i_desc_byte),
        .i_last_byte    (i_last_byte),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_record_kind  (o_record_kind),
        .o_bit_offset   (o_bit_offset),
        .o_field_size   (o_field_size),
        .o_field_count  (o_field_count),
        .o_minimum      (o_minimum),
        .o_maximum      (o_maximum),
        .o_min_known    (o_min_known),
        .o_max_known    (o_max_known),
        .o_report_bytes (o_report_bytes),
        .o_axis_count   (o_axis_count),
        .o_hat_count    (o_hat_count),
        .o_last_result  (o_last_result)
    );

endmodule
`default_nettype wire
